FILE: rtl/pors_pkg.sv
// Shared types and constants for the priority-ordered run scheduler.
package pors_pkg;

  localparam int NAME_W  = 8;
  localparam int LEN_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int CLOCK_W = 32;
  localparam int OCC_W   = 5;

  // Action codes carried by the input item.
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // One queue slot as it sits in the table memory.
  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  remaining;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted item, clear the result
    logic rd_tail;     // point at the tail, read the last entry
    logic ins_shift;   // move the read entry back one slot, read the one ahead
    logic ins_place;   // write the new entry at the current slot
    logic reject;      // flag the add as refused
    logic rd_head;     // read the head entry
    logic head_run;    // report the head and advance the time counter
    logic head_dec;    // write the head back with one unit less
    logic drop_begin;  // start closing the gap left by the head
    logic drop_step;   // move the read entry forward one slot
    logic count_dec;   // one entry fewer
    logic finish;      // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic len_zero;
    logic full;
    logic empty;
    logic stop;        // new priority is above the entry just read
    logic idx_one;
    logic head_last;   // head has at most one unit left
    logic count_one;
    logic drop_last;
    logic out_busy;    // output register holds a result that is not taken
  } stat_t;

endpackage

FILE: rtl/priority_ordered_run_scheduler.sv
// Top level of the preemptive priority run scheduler.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  action, proc_name, run_length, prio_value
//   out      output     out_valid/out_stall  ran, ran_name, run_clock, rejected,
//                                            occupancy
//
// An add scans from the tail, moving each entry behind the new one back one slot
// (up to QUEUE_DEPTH - 1 entries), places the new entry and loads the output
// register; a refused or zero-time add skips to that load. A tick reads and runs
// the head, closes the gap when the head finishes, then loads; on an empty queue
// it skips to the load. The next item is taken from the cycle after the result
// loads. The table moves one entry per cycle via its single read and write port.
// Reset clears the entry count and time counter; the table itself is not swept.
// A result waits in the output register while out_stall is high; the next
// item is taken meanwhile and holds in its last cycle until that transfer.
module priority_ordered_run_scheduler import pors_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [NAME_W-1:0]  proc_name,
  input  logic [LEN_W-1:0]   run_length,
  input  logic [PRIO_W-1:0]  prio_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ran,
  output logic [NAME_W-1:0]  ran_name,
  output logic [CLOCK_W-1:0] run_clock,
  output logic               rejected,
  output logic [OCC_W-1:0]   occupancy
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  pors_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table, counters and output register.
  pors_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (action),
    .proc_name  (proc_name),
    .run_length (run_length),
    .prio_value (prio_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ran        (ran),
    .ran_name   (ran_name),
    .run_clock  (run_clock),
    .rejected   (rejected),
    .occupancy  (occupancy)
  );

endmodule

FILE: rtl/pors_ram.sv
// Generic single-write, single-read memory with a registered read port.
module pors_ram import pors_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/pors_ctrl.sv
// Controller state machine that sequences adds and ticks over the queue table.
module pors_ctrl import pors_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_INS_SCAN = 3'd2;
  localparam logic [2:0] ST_INS_PUT  = 3'd3;
  localparam logic [2:0] ST_HEAD     = 3'd4;
  localparam logic [2:0] ST_DROP     = 3'd5;
  localparam logic [2:0] ST_FINISH   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // One item is worked on at a time; the input waits outside idle.
  assign in_stall = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.is_add) begin
          if (stat.len_zero) begin
            state_next = ST_FINISH;
          end else if (stat.full) begin
            cmd.reject = 1'b1;
            state_next = ST_FINISH;
          end else begin
            cmd.rd_tail = 1'b1;
            state_next  = stat.empty ? ST_INS_PUT : ST_INS_SCAN;
          end
        end else begin
          if (stat.empty) begin
            state_next = ST_FINISH;
          end else begin
            cmd.rd_head = 1'b1;
            state_next  = ST_HEAD;
          end
        end
      end
      ST_INS_SCAN: begin
        // Walk from the tail toward the head, moving entries back by one.
        if (stat.stop) begin
          cmd.ins_place = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          cmd.ins_shift = 1'b1;
          if (stat.idx_one) begin
            state_next = ST_INS_PUT;
          end
        end
      end
      ST_INS_PUT: begin
        cmd.ins_place = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_HEAD: begin
        cmd.head_run = 1'b1;
        if (stat.head_last) begin
          if (stat.count_one) begin
            cmd.count_dec = 1'b1;
            state_next    = ST_FINISH;
          end else begin
            cmd.drop_begin = 1'b1;
            state_next     = ST_DROP;
          end
        end else begin
          cmd.head_dec = 1'b1;
          state_next   = ST_FINISH;
        end
      end
      ST_DROP: begin
        cmd.drop_step = 1'b1;
        if (stat.drop_last) begin
          cmd.count_dec = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/pors_dp.sv
// Datapath: item registers, queue table memory, counters and the output register.
module pors_dp import pors_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               action,
  input  logic [NAME_W-1:0]  proc_name,
  input  logic [LEN_W-1:0]   run_length,
  input  logic [PRIO_W-1:0]  prio_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ran,
  output logic [NAME_W-1:0]  ran_name,
  output logic [CLOCK_W-1:0] run_clock,
  output logic               rejected,
  output logic [OCC_W-1:0]   occupancy
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Accepted item.
  logic              it_act;
  logic [NAME_W-1:0] it_name;
  logic [LEN_W-1:0]  it_len;
  logic [PRIO_W-1:0] it_prio;

  // Queue bookkeeping and time counter.
  logic [CW-1:0]      idx;
  logic [CW-1:0]      count;
  logic [CLOCK_W-1:0] elapsed;

  // Result being built for the current item.
  logic               res_ran;
  logic [NAME_W-1:0]  res_name;
  logic [CLOCK_W-1:0] res_clock;
  logic               res_rej;

  // Memory ports.
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_raw;

  entry_t        rd_entry;
  entry_t        new_entry;
  entry_t        dec_entry;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_m2;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] count_m1;

  pors_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry  = entry_t'(rd_raw);
  assign new_entry = '{name: it_name, remaining: it_len, prio: it_prio};
  assign dec_entry = '{name: rd_entry.name, remaining: rd_entry.remaining - LEN_W'(1),
                       prio: rd_entry.prio};
  assign idx_m1    = idx - CW'(1);
  assign idx_m2    = idx - CW'(2);
  assign idx_p1    = idx + CW'(1);
  assign count_m1  = count - CW'(1);

  // Status for the controller.
  always_comb begin
    stat.is_add    = (it_act == ACT_ADD);
    stat.len_zero  = (it_len == '0);
    stat.full      = (count == CW'(QUEUE_DEPTH));
    stat.empty     = (count == '0);
    stat.stop      = (it_prio > rd_entry.prio);
    stat.idx_one   = (idx == CW'(1));
    stat.head_last = (rd_entry.remaining <= LEN_W'(1));
    stat.count_one = (count == CW'(1));
    stat.drop_last = (idx_p1 == count);
    stat.out_busy  = out_valid && out_stall;
  end

  // Table write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_raw;
    if (cmd.ins_shift) begin
      wr_en = 1'b1;
    end
    if (cmd.ins_place) begin
      wr_en   = 1'b1;
      wr_data = new_entry;
    end
    if (cmd.head_dec) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = dec_entry;
    end
    if (cmd.drop_step) begin
      wr_en   = 1'b1;
      wr_addr = idx_m1[AW-1:0];
    end
  end

  // Table read port; each read is issued in the cycle before its data is used.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.rd_tail) begin
      rd_en   = !stat.empty;
      rd_addr = count_m1[AW-1:0];
    end
    if (cmd.rd_head) begin
      rd_en = 1'b1;
    end
    if (cmd.ins_shift) begin
      rd_en   = !stat.idx_one;
      rd_addr = idx_m2[AW-1:0];
    end
    if (cmd.drop_begin) begin
      rd_en   = 1'b1;
      rd_addr = AW'(1);
    end
    if (cmd.drop_step) begin
      rd_en   = !stat.drop_last;
      rd_addr = idx_p1[AW-1:0];
    end
  end

  // Item capture, slot index and result staging.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_act    <= action;
      it_name   <= proc_name;
      it_len    <= run_length;
      it_prio   <= prio_value;
      res_ran   <= 1'b0;
      res_name  <= '0;
      res_clock <= '0;
      res_rej   <= 1'b0;
    end
    if (cmd.rd_tail) begin
      idx <= count;
    end
    if (cmd.ins_shift) begin
      idx <= idx_m1;
    end
    if (cmd.drop_begin) begin
      idx <= CW'(1);
    end
    if (cmd.drop_step) begin
      idx <= idx_p1;
    end
    if (cmd.head_run) begin
      res_ran   <= 1'b1;
      res_name  <= rd_entry.name;
      res_clock <= elapsed;
    end
    if (cmd.reject) begin
      res_rej <= 1'b1;
    end
    if (cmd.finish) begin
      ran       <= res_ran;
      ran_name  <= res_name;
      run_clock <= res_clock;
      rejected  <= res_rej;
      occupancy <= OCC_W'(count);
    end
  end

  // Entry count, time counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      elapsed   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_place) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count_m1;
      end
      if (cmd.head_run) begin
        elapsed <= elapsed + CLOCK_W'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the priority-ordered run scheduler.
`timescale 1ns / 100ps

module testbench;
  import pors_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RAND_JOBS   = 475;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;

  // One input transfer and one result transfer.
  typedef struct packed {
    logic              action;
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
    logic [PRIO_W-1:0] prio;
  } job_t;

  typedef struct packed {
    logic               ran;
    logic [NAME_W-1:0]  name;
    logic [CLOCK_W-1:0] clock;
    logic               rejected;
    logic [OCC_W-1:0]   occ;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = ACT_ADD;
  logic [NAME_W-1:0]  proc_name = '0;
  logic [LEN_W-1:0]   run_length = '0;
  logic [PRIO_W-1:0]  prio_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ran;
  logic [NAME_W-1:0]  ran_name;
  logic [CLOCK_W-1:0] run_clock;
  logic               rejected;
  logic [OCC_W-1:0]   occupancy;

  // Jobs waiting to be offered and outcomes waiting to come back.
  job_t     job_backlog[$];
  outcome_t outcomes_due[$];

  // Shadow copy of the scheduler table.
  logic [NAME_W-1:0]  sched_name[QUEUE_DEPTH];
  logic [LEN_W-1:0]   sched_left[QUEUE_DEPTH];
  logic [PRIO_W-1:0]  sched_prio[QUEUE_DEPTH];
  int                 sched_count = 0;
  logic [CLOCK_W-1:0] sched_clock = '0;

  int  err_count = 0;
  int  total_jobs = 0;
  int  jobs_taken = 0;
  int  press_at = 0;
  bit  press_done = 0;
  int  hold_left = 0;
  bit  in_took = 0;
  int  quiet_cycles = 0;
  int  n_add = 0, n_tick = 0, n_reject = 0, n_zero = 0, n_run = 0, n_empty_tick = 0;
  int  peak_occ = 0;

  priority_ordered_run_scheduler #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .proc_name(proc_name), .run_length(run_length),
    .prio_value(prio_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .ran(ran), .ran_name(ran_name), .run_clock(run_clock),
    .rejected(rejected), .occupancy(occupancy)
  );

  // Clock generation.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one job to the shadow table and return the outcome it should produce.
  function automatic outcome_t dispatch_predict(job_t j);
    outcome_t o;
    int       pos;
    int       i;
    o = '0;
    if (j.action == ACT_ADD) begin
      if (j.len != 0) begin
        if (sched_count >= QUEUE_DEPTH) begin
          o.rejected = 1'b1;
        end else begin
          pos = 0;
          while (pos < sched_count && j.prio > sched_prio[pos]) pos++;
          for (i = sched_count; i > pos; i--) begin
            sched_name[i] = sched_name[i-1];
            sched_left[i] = sched_left[i-1];
            sched_prio[i] = sched_prio[i-1];
          end
          sched_name[pos] = j.name;
          sched_left[pos] = j.len;
          sched_prio[pos] = j.prio;
          sched_count++;
        end
      end
    end else if (sched_count > 0) begin
      o.ran   = 1'b1;
      o.name  = sched_name[0];
      o.clock = sched_clock;
      sched_clock = sched_clock + 1'b1;
      if (sched_left[0] <= 1) begin
        for (i = 1; i < sched_count; i++) begin
          sched_name[i-1] = sched_name[i];
          sched_left[i-1] = sched_left[i];
          sched_prio[i-1] = sched_prio[i];
        end
        sched_count--;
      end else begin
        sched_left[0] = sched_left[0] - 1'b1;
      end
    end
    o.occ = OCC_W'(sched_count);
    return o;
  endfunction

  task automatic check_field(string fname, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", fname, exp_v, act_v);
      err_count++;
    end
  endtask

  task automatic push_add(int nm, int len, int pr);
    job_t j;
    j.action = ACT_ADD;
    j.name   = NAME_W'(nm);
    j.len    = LEN_W'(len);
    j.prio   = PRIO_W'(pr);
    job_backlog.push_back(j);
  endtask

  task automatic push_tick(int nm, int len, int pr);
    job_t j;
    j.action = ACT_TICK;
    j.name   = NAME_W'(nm);
    j.len    = LEN_W'(len);
    j.prio   = PRIO_W'(pr);
    job_backlog.push_back(j);
  endtask

  // Monitor: check result transfers, predict on input transfers.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    job_t     j;
    in_took = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{ran, ran_name, run_clock, rejected, occupancy};
        if (outcomes_due.size() == 0) begin
          $error("result transfer with no outcome pending");
          err_count++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("ran", want.ran, got.ran);
          check_field("ran_name", want.name, got.name);
          check_field("run_clock", want.clock, got.clock);
          check_field("rejected", want.rejected, got.rejected);
          check_field("occupancy", want.occ, got.occ);
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        jobs_taken++;
        j = '{action, proc_name, run_length, prio_value};
        want = dispatch_predict(j);
        outcomes_due.push_back(want);
        if (j.action == ACT_ADD) begin
          n_add++;
          if (j.len == 0) n_zero++;
          if (want.rejected) n_reject++;
        end else begin
          n_tick++;
          if (want.ran) n_run++;
          else n_empty_tick++;
        end
        if (sched_count > peak_occ) peak_occ = sched_count;
      end
    end
  end

  // Driver: offer backlog jobs at the falling edge, with random gaps by phase.
  always @(negedge clk) begin
    int   gap_pct;
    int   phase;
    job_t j;
    if (!rst && (!in_valid || in_took)) begin
      phase = (total_jobs > 0) ? (jobs_taken * 3) / total_jobs : 0;
      gap_pct = (phase == 0) ? 34 : (phase == 1) ? 60 : 0;
      if (job_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        j = job_backlog.pop_front();
        action     <= j.action;
        proc_name  <= j.name;
        run_length <= j.len;
        prio_value <= j.prio;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls by phase, plus one long hold-off to back up the block.
  always @(negedge clk) begin
    int phase;
    phase = (total_jobs > 0) ? (jobs_taken * 3) / total_jobs : 0;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!press_done && press_at > 0 && jobs_taken >= press_at) begin
      press_done = 1;
      hold_left  = HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < ((phase == 0) ? 60 : (phase == 1) ? 34 : 0));
    end
  end

  // Watchdog on stretches with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int mode;
    int burst;
    int n;
    int r;
    int len;
    int pr;

    // Directed: empty tick, zero-time add, field extremes, ties, full queue.
    push_tick(8'hA5, 16'hFFFF, 8'hFF);
    push_add(0, 0, 0);
    push_add(8'hFF, 16'hFFFF, 8'hFF);
    push_add(1, 1, 0);
    push_tick(0, 0, 0);
    for (n = 0; n < 14; n++) begin
      push_add(8'h41 + n, 1 + (n % 3), (n * 3) % 5);
    end
    push_add(8'h80, 2, 0);
    push_add(8'h81, 5, 1);
    push_add(8'h82, 0, 1);
    push_tick(8'hFF, 16'h0000, 8'h00);
    push_tick(8'h00, 16'hFFFF, 8'hFF);

    // Random bursts: add-heavy, tick-heavy and balanced stretches.
    n = 0;
    while (n < RAND_JOBS) begin
      mode  = $urandom_range(0, 2);
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if ((mode == 0 && r < 80) || (mode == 1 && r < 20) || (mode == 2 && r < 50)) begin
          r = $urandom_range(0, 99);
          pr = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 255);
          if (r < 5) begin
            len = 0;
          end else if (r < 7) begin
            // Long jobs go to the back so they do not hold the head forever.
            len = $urandom_range(0, 65535);
            pr  = $urandom_range(224, 255);
          end else begin
            len = $urandom_range(1, 6);
          end
          push_add($urandom_range(0, 255), len, pr);
        end else begin
          push_tick($urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 255));
        end
        n++;
      end
    end
    total_jobs = job_backlog.size();
    press_at   = (2 * total_jobs) / 3 + 10;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (job_backlog.size() != 0 || in_valid) @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d adds (%0d zero-time, %0d refused on full) and %0d ticks",
             n_add, n_zero, n_reject, n_tick);
    $display("(%0d ran a job, %0d on an empty queue); peak occupancy %0d of %0d.",
             n_run, n_empty_tick, peak_occ, QUEUE_DEPTH);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
